FILE: src/ascii_angle_to_servo_pulse_macros.svh
// Assertion macros for the servo pulse decoder.
// Expects clk and rst in scope at the point of use.
`ifndef ASCII_ANGLE_TO_SERVO_PULSE_MACROS_SVH
`define ASCII_ANGLE_TO_SERVO_PULSE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define AASP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define AASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/aasp_pkg.sv
// Shared widths, register codes, reset values and a helper function
// for the servo pulse decoder. No dependencies.
`default_nettype none

package aasp_pkg;

  // Field and register widths
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 3;
  localparam int CH_W      = 3;
  localparam int SUM_W     = 18;
  localparam int ANGLE_W   = 18;
  localparam int ANGLE_X_W = 19;
  localparam int BIAS_W    = 17;
  localparam int CAL_W     = 29;
  localparam int GAIN_W    = 17;
  localparam int OFS_W     = 12;
  localparam int PULSE_W   = 12;
  localparam int REG_IDX_W = 3;
  localparam int NUM_CAL   = 6;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_BIAS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAL_FIRST  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL_LAST   = 3'd6;

  // Reset values
  localparam logic [BIAS_W-1:0] BIAS_RESET = 17'd60000;
  localparam logic [CAL_W-1:0] CAL_RESET [NUM_CAL] = '{
    29'd193436000, 29'd159748163, 29'd171285932,
    29'd160517688, 29'd191470680, 29'd252025944
  };

  // Division by 10^7: drop 7 bits, then multiply by reciprocal of 78125.
  // Dividend after the shift is below 2^28; m = ceil(2^45 / 78125) is exact.
  localparam int MAG_W       = 18;
  localparam int PROD_W      = 35;
  localparam int PRE_SHIFT   = 7;
  localparam int QIN_W       = 28;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 45;
  localparam int QPROD_W     = 57;
  localparam int QUO_W       = 12;
  localparam int PSUM_W      = 14;
  localparam logic [RECIP_W-1:0] RECIP_78125 = 29'd450359963;

  localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;
  localparam logic signed [ANGLE_X_W-1:0] ANGLE_SAT_MIN = -19'sd131072;

  // Signed contribution of one character at a digit position
  function automatic logic signed [SUM_W-1:0] char_term(
    input logic [CHAR_W-1:0] ch,
    input logic [POS_W-1:0]  pos
  );
    logic signed [4:0]       v;
    logic signed [14:0]      w;
    logic signed [SUM_W-1:0] ve;
    logic signed [SUM_W-1:0] we;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = signed'({1'b0, ch[3:0]});
    end else begin
      v = -5'sd1;
    end
    case (pos)
      3'd0:    w = 15'sd1;
      3'd1:    w = 15'sd10;
      3'd2:    w = 15'sd100;
      3'd3:    w = 15'sd1000;
      3'd4:    w = 15'sd10000;
      default: w = 15'sd0;
    endcase
    ve = SUM_W'(v);
    we = SUM_W'(w);
    return ve * we;
  endfunction

endpackage

`default_nettype wire

FILE: src/aasp_ifs.sv
// Valid/ready channel interfaces for the servo pulse decoder.
// Depends on aasp_pkg for field widths.
`default_nettype none

// Received character channel
interface aasp_rx_if;
  logic                         valid;
  logic                         ready;
  logic [aasp_pkg::CHAR_W-1:0]  rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

// Decoded result channel
interface aasp_res_if;
  logic                               valid;
  logic                               ready;
  logic [aasp_pkg::CH_W-1:0]          channel;
  logic signed [aasp_pkg::ANGLE_W-1:0] angle_milli;
  logic [aasp_pkg::PULSE_W-1:0]       pulse_us;
  logic                               frame_last;
  modport source (output valid, output channel, output angle_milli,
                  output pulse_us, output frame_last, input ready);
  modport sink   (input valid, input channel, input angle_milli,
                  input pulse_us, input frame_last, output ready);
endinterface

// Register write channel
interface aasp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aasp_pkg::REG_IDX_W-1:0]  index;
  logic [aasp_pkg::CAL_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ascii_angle_to_servo_pulse.sv
// Serial ASCII angle decoder producing servo pulse widths, top level.
// Depends on aasp_pkg, aasp_ifs and ascii_angle_to_servo_pulse_macros.svh.
`default_nettype none
`include "ascii_angle_to_servo_pulse_macros.svh"

// Takes one received character per clock on rx. DIGITS_PER_FIELD characters
// (least significant digit first) form one channel field; CHANNELS fields
// form a frame. A digit counts as its value, any other character as minus
// one. The character closing a field enters a three-stage pipe: angle and
// calibration select, gain multiply, reciprocal multiply with offset add and
// saturation into the output register. A result reaches res through stage 1,
// stage 2 and the output register; one character is taken every cycle as
// long as the pipe can move, and the pipe stalls only when res is held back
// with every stage full. Register writes on cfg are always taken and apply
// to fields that close after the write.
module ascii_angle_to_servo_pulse #(
  parameter int CHANNELS         = 6,
  parameter int DIGITS_PER_FIELD = 5
) (
  input  logic               clk,
  input  logic               rst,
  aasp_rx_if.sink            rx,
  aasp_res_if.source         res,
  aasp_cfg_if.sink           cfg
);

  localparam logic [aasp_pkg::POS_W-1:0] LAST_POS = aasp_pkg::POS_W'(DIGITS_PER_FIELD - 1);
  localparam logic [aasp_pkg::CH_W-1:0]  LAST_CH  = aasp_pkg::CH_W'(CHANNELS - 1);

  // Configuration registers
  logic [aasp_pkg::BIAS_W-1:0] angle_bias_milli;
  logic [aasp_pkg::CAL_W-1:0]  cal_channel [aasp_pkg::NUM_CAL];

  // Field accumulation state
  logic [aasp_pkg::POS_W-1:0]        digit_position;
  logic [aasp_pkg::CH_W-1:0]         channel_index;
  logic signed [aasp_pkg::SUM_W-1:0] digit_sum;

  // Stage 1: angle and calibration
  logic                                  s1_valid;
  logic signed [aasp_pkg::ANGLE_X_W-1:0] s1_angle;
  logic [aasp_pkg::GAIN_W-1:0]           s1_gain;
  logic [aasp_pkg::OFS_W-1:0]            s1_offset;
  logic [aasp_pkg::CH_W-1:0]             s1_channel;
  logic                                  s1_last;

  // Stage 2: scaled magnitude
  logic                                s2_valid;
  logic [aasp_pkg::QIN_W-1:0]          s2_qin;
  logic                                s2_neg;
  logic [aasp_pkg::OFS_W-1:0]          s2_offset;
  logic signed [aasp_pkg::ANGLE_W-1:0] s2_angle;
  logic [aasp_pkg::CH_W-1:0]           s2_channel;
  logic                                s2_last;

  // Stage 3: output register
  logic                                out_valid;
  logic [aasp_pkg::CH_W-1:0]           out_channel;
  logic signed [aasp_pkg::ANGLE_W-1:0] out_angle;
  logic [aasp_pkg::PULSE_W-1:0]        out_pulse;
  logic                                out_last;

  logic s3_free, s2_free, s1_free;
  logic rx_fire, cfg_fire, field_end;
  logic signed [aasp_pkg::SUM_W-1:0]     sum_next;
  logic signed [aasp_pkg::ANGLE_X_W-1:0] angle_x;
  logic [aasp_pkg::CAL_W-1:0]            cal_sel;
  logic [aasp_pkg::ANGLE_X_W-1:0]        abs_x;
  logic [aasp_pkg::PROD_W-1:0]           gain_prod;
  logic signed [aasp_pkg::ANGLE_W-1:0]   angle_rep;
  logic [aasp_pkg::QPROD_W-1:0]          q_prod;
  logic [aasp_pkg::QUO_W-1:0]            quo;
  logic signed [aasp_pkg::PSUM_W-1:0]    quo_s;
  logic signed [aasp_pkg::PSUM_W-1:0]    psum;
  logic [aasp_pkg::PULSE_W-1:0]          pulse_sat;

  // Handshakes and pipe flow
  assign s3_free   = !out_valid || res.ready;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign rx.ready  = s1_free;
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign field_end = (digit_position == LAST_POS);

  // Register writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_bias_milli <= aasp_pkg::BIAS_RESET;
      for (int i = 0; i < aasp_pkg::NUM_CAL; i++) begin
        cal_channel[i] <= aasp_pkg::CAL_RESET[i];
      end
    end else if (cfg_fire) begin
      if (cfg.index == aasp_pkg::REG_ANGLE_BIAS) begin
        angle_bias_milli <= cfg.data[aasp_pkg::BIAS_W-1:0];
      end else if (cfg.index >= aasp_pkg::REG_CAL_FIRST &&
                   cfg.index <= aasp_pkg::REG_CAL_LAST) begin
        cal_channel[cfg.index - aasp_pkg::REG_CAL_FIRST] <= cfg.data;
      end
    end
  end

  // Digit accumulation
  assign sum_next = digit_sum + aasp_pkg::char_term(rx.rx_char, digit_position);
  assign angle_x  = aasp_pkg::ANGLE_X_W'(sum_next)
                  - signed'({2'b00, angle_bias_milli});
  assign cal_sel  = cal_channel[channel_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_position <= '0;
      channel_index  <= '0;
      digit_sum      <= '0;
    end else if (rx_fire) begin
      if (field_end) begin
        digit_position <= '0;
        digit_sum      <= '0;
        channel_index  <= (channel_index == LAST_CH) ? '0 : channel_index + 1'b1;
      end else begin
        digit_position <= digit_position + 1'b1;
        digit_sum      <= sum_next;
      end
    end
  end

  // Stage 1 load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= rx_fire && field_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_angle   <= angle_x;
      s1_gain    <= cal_sel[aasp_pkg::GAIN_W-1:0];
      s1_offset  <= cal_sel[aasp_pkg::CAL_W-1:aasp_pkg::GAIN_W];
      s1_channel <= channel_index;
      s1_last    <= (channel_index == LAST_CH);
    end
  end

  // Stage 2: |gain * angle| / 128, reported angle clamp
  assign abs_x     = s1_angle[aasp_pkg::ANGLE_X_W-1] ? aasp_pkg::ANGLE_X_W'(-s1_angle)
                                                      : aasp_pkg::ANGLE_X_W'(s1_angle);
  assign gain_prod = aasp_pkg::PROD_W'(s1_gain) * aasp_pkg::PROD_W'(abs_x[aasp_pkg::MAG_W-1:0]);
  assign angle_rep = (s1_angle < aasp_pkg::ANGLE_SAT_MIN)
                   ? aasp_pkg::ANGLE_W'(aasp_pkg::ANGLE_SAT_MIN)
                   : s1_angle[aasp_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_qin     <= gain_prod[aasp_pkg::PROD_W-1:aasp_pkg::PRE_SHIFT];
      s2_neg     <= s1_angle[aasp_pkg::ANGLE_X_W-1];
      s2_offset  <= s1_offset;
      s2_angle   <= angle_rep;
      s2_channel <= s1_channel;
      s2_last    <= s1_last;
    end
  end

  // Stage 3: divide by 78125, restore sign, add offset, saturate
  assign q_prod = aasp_pkg::QPROD_W'(s2_qin) * aasp_pkg::QPROD_W'(aasp_pkg::RECIP_78125);
  assign quo    = q_prod[aasp_pkg::QPROD_W-1:aasp_pkg::RECIP_SHIFT];
  assign quo_s  = s2_neg ? -signed'({2'b00, quo}) : signed'({2'b00, quo});
  assign psum   = signed'({2'b00, s2_offset}) + quo_s;

  always_comb begin
    if (psum < 0) begin
      pulse_sat = '0;
    end else if (psum > signed'({2'b00, aasp_pkg::PULSE_MAX})) begin
      pulse_sat = aasp_pkg::PULSE_MAX;
    end else begin
      pulse_sat = psum[aasp_pkg::PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      out_channel <= s2_channel;
      out_angle   <= s2_angle;
      out_pulse   <= pulse_sat;
      out_last    <= s2_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.channel     = out_channel;
  assign res.angle_milli = out_angle;
  assign res.pulse_us    = out_pulse;
  assign res.frame_last  = out_last;

  // Checks
  `AASP_ASSERT_NOW(a_pos_range, 1'b1, digit_position <= LAST_POS, "digit position past end")
  `AASP_ASSERT_NOW(a_ch_range, out_valid, out_channel <= LAST_CH, "result channel out of range")
  `AASP_ASSERT_NOW(a_last_ch, out_valid && out_last, out_channel == LAST_CH, "frame flag misplaced")
  `AASP_ASSERT_NEXT(a_s1_hold, s1_valid && !s2_free, s1_valid, "stage 1 item dropped")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for ascii_angle_to_servo_pulse: random characters, calibration phases.
// Depends on aasp_pkg, aasp_ifs and the decoder RTL; holds its own bit-exact decoder mirror.
module tb;

  localparam int FIELD_LEN     = 5;
  localparam int NUM_CHANNELS  = 6;
  localparam int IDLE_PCT      = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_CHARS   = 150;
  localparam int CALM_PHASE    = 3;
  localparam int REPORT_MAX    = 10;
  localparam logic [aasp_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Opening fields: all zeros, all nines, non-digits with extreme codes, mixed
  localparam logic [aasp_pkg::CHAR_W-1:0] OPENING [25] = '{
    "0", "0", "0", "0", "0",
    "9", "9", "9", "9", "9",
    "/", ":", 8'h00, 8'hFF, " ",
    "5", "4", "3", "2", "1",
    "9", 8'h80, "0", "7", 8'h7F
  };

  typedef struct packed {
    logic [aasp_pkg::CH_W-1:0]           channel;
    logic signed [aasp_pkg::ANGLE_W-1:0] angle_milli;
    logic [aasp_pkg::PULSE_W-1:0]        pulse_us;
    logic                                frame_last;
  } servo_result_t;

  // Mirror of the decoder: register file, field accumulator, awaited results
  class servo_decode_mirror;
    logic [aasp_pkg::BIAS_W-1:0] bias;
    logic [aasp_pkg::CAL_W-1:0]  cal [aasp_pkg::NUM_CAL];
    int                          pos;
    int                          chan;
    int                          sum;
    int                          errors;
    servo_result_t               awaited [$];

    function new();
      bias = aasp_pkg::BIAS_RESET;
      foreach (cal[i]) cal[i] = aasp_pkg::CAL_RESET[i];
      pos = 0;
      chan = 0;
      sum = 0;
      errors = 0;
    endfunction

    function void write_reg(input logic [aasp_pkg::REG_IDX_W-1:0] idx,
                            input logic [aasp_pkg::CAL_W-1:0] data);
      if (idx == aasp_pkg::REG_ANGLE_BIAS) begin
        bias = data[aasp_pkg::BIAS_W-1:0];
      end else if (idx >= aasp_pkg::REG_CAL_FIRST && idx <= aasp_pkg::REG_CAL_LAST) begin
        cal[idx - aasp_pkg::REG_CAL_FIRST] = data;
      end
    endfunction

    // Accumulate one character; the last one of a field yields a result
    function void take_char(input logic [aasp_pkg::CHAR_W-1:0] c);
      int            digit;
      int            weight;
      longint        offset;
      longint        gain;
      longint        angle;
      longint        pulse;
      longint        shown;
      servo_result_t r;
      digit = (c >= "0" && c <= "9") ? int'(c) - 48 : -1;
      weight = 1;
      repeat (pos) weight *= 10;
      sum += digit * weight;
      if (pos < FIELD_LEN - 1) begin
        pos++;
        return;
      end
      offset = longint'(cal[chan][aasp_pkg::CAL_W-1:aasp_pkg::GAIN_W]);
      gain   = longint'(cal[chan][aasp_pkg::GAIN_W-1:0]);
      angle  = longint'(sum) - longint'(bias);
      // signed division truncates toward zero
      pulse  = offset + (gain * angle) / 64'sd10000000;
      if (pulse < 0) pulse = 0;
      if (pulse > 4095) pulse = 4095;
      shown = angle;
      if (shown < -131072) shown = -131072;
      if (shown > 131071) shown = 131071;
      r.channel     = chan[aasp_pkg::CH_W-1:0];
      r.angle_milli = shown[aasp_pkg::ANGLE_W-1:0];
      r.pulse_us    = pulse[aasp_pkg::PULSE_W-1:0];
      r.frame_last  = (chan == NUM_CHANNELS - 1);
      awaited.push_back(r);
      pos = 0;
      sum = 0;
      chan = (chan == NUM_CHANNELS - 1) ? 0 : chan + 1;
    endfunction

    function void check_result(input servo_result_t got);
      servo_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: ch %0d angle %0d pulse %0d last %0b",
                   got.channel, got.angle_milli, got.pulse_us, got.frame_last);
        return;
      end
      want = awaited.pop_front();
      if (got.channel !== want.channel || got.angle_milli !== want.angle_milli ||
          got.pulse_us !== want.pulse_us || got.frame_last !== want.frame_last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: exp ch %0d angle %0d pulse %0d last %0b,",
                   want.channel, want.angle_milli, want.pulse_us, want.frame_last,
                   " got ch %0d angle %0d pulse %0d last %0b",
                   got.channel, got.angle_milli, got.pulse_us, got.frame_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int   quiet_cycles = 0;

  servo_decode_mirror mirror = new();

  aasp_rx_if  rx ();
  aasp_res_if res ();
  aasp_cfg_if cfg ();

  ascii_angle_to_servo_pulse dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result sink with random back-pressure, always ready in the calm phase
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (calm) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: register writes, accepted characters, accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) mirror.write_reg(cfg.index, cfg.data);
      if (rx.valid && rx.ready) mirror.take_char(rx.rx_char);
      if (res.valid && res.ready)
        mirror.check_result(servo_result_t'{res.channel, res.angle_milli,
                                            res.pulse_us, res.frame_last});
    end
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_char(input logic [aasp_pkg::CHAR_W-1:0] c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_char <= c;
    do @(posedge clk); while (!rx.ready);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic put_reg(input logic [aasp_pkg::REG_IDX_W-1:0] idx,
                         input logic [aasp_pkg::CAL_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Wait until every awaited result has come out, then let the bench idle
  task automatic settle();
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly digits so fields decode to sensible angles; the rest is any byte
  function automatic logic [aasp_pkg::CHAR_W-1:0] field_char();
    if ($urandom_range(99) < 85) return 8'h30 + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [aasp_pkg::CAL_W-1:0] bias_word;
    logic [aasp_pkg::CAL_W-1:0] cal_words [aasp_pkg::NUM_CAL];
    rx.valid   = 1'b0;
    rx.rx_char = '0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed fields under reset calibration
    foreach (OPENING[i]) send_char(OPENING[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      rx.valid <= 1'b0;
      settle();

      // Calibration for this phase: zeros, all ones, saturation mix, random, reset
      for (int k = 0; k < aasp_pkg::NUM_CAL; k++) begin
        case (phase)
          0: cal_words[k] = '0;
          1: cal_words[k] = '1;
          2: cal_words[k] = (k % 2 == 0) ? {12'd0, 17'h1FFFF} : {12'hFFF, 17'd0};
          5: cal_words[k] = aasp_pkg::CAL_RESET[k];
          default: cal_words[k] = aasp_pkg::CAL_W'($urandom());
        endcase
      end
      case (phase)
        0: bias_word = '0;
        1: bias_word = '1;
        2: bias_word = {12'd0, 17'h1FFFF};
        5: bias_word = {12'd0, aasp_pkg::BIAS_RESET};
        default: bias_word = aasp_pkg::CAL_W'($urandom());
      endcase

      put_reg(aasp_pkg::REG_ANGLE_BIAS, bias_word);
      for (int k = 0; k < aasp_pkg::NUM_CAL; k++)
        put_reg(aasp_pkg::REG_IDX_W'(aasp_pkg::REG_CAL_FIRST + k), cal_words[k]);
      put_reg(REG_SPARE, aasp_pkg::CAL_W'($urandom()));
      cfg.valid <= 1'b0;
      calm <= (phase == CALM_PHASE);

      repeat (PHASE_CHARS) send_char(field_char());
    end

    rx.valid <= 1'b0;
    settle();

    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/aasp_pkg.sv
src/aasp_ifs.sv
src/ascii_angle_to_servo_pulse.sv
tb/tb.sv
